// ===== design/sts_pkg.sv =====
package sts_pkg;

  localparam int TEXT_W = 48;
  localparam int LEN_W  = 3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic [1:0] {
    ST_TOKEN    = 2'd0,
    ST_END      = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    status_t           status;
    logic              last;
  } result_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_QUOTE) || (b == CH_NUL);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

endpackage

// ===== design/sexpr_token_scanner.sv =====
// Results are registered into a three-entry result queue and offered from its
// head in order; the second result of a closing delimiter queues behind the first.
// Throughput: one byte per cycle while the queue holds fewer than two results;
// input stalls while the queue holds two or more results.
// Reset (rst_n, synchronous): scanner state returns outside any token or
// comment and the result queue empties.
module sexpr_token_scanner
  import sts_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEXT_W-1:0] out_token_text,
  output logic [LEN_W-1:0]  out_token_length,
  output logic [1:0]        out_status,
  output logic              out_last_of_run
);

  localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int QD = 3;

  logic          in_comment_r, in_comment_nxt;
  logic          in_atom_r, in_atom_nxt;
  logic [7:0]    atom_chars_r [MAX_TOKEN_CHARS];
  logic [7:0]    atom_chars_nxt [MAX_TOKEN_CHARS];
  logic [CW-1:0] atom_count_r, atom_count_nxt;

  result_t       q_r [QD];
  result_t       q_nxt [QD];
  logic [1:0]    q_count_r, q_count_nxt;

  logic          accept, pop;
  logic [1:0]    n_push;
  result_t       res0, res1;
  logic [63:0]   packed_atom;
  logic [3:0]    count_ext;
  result_t       atom_res;
  result_t       delim_res;

  assign in_stall  = (q_count_r >= 2'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (q_count_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  assign out_token_text   = q_r[0].text;
  assign out_token_length = q_r[0].len;
  assign out_status       = q_r[0].status;
  assign out_last_of_run  = q_r[0].last;

  // Token text is packed first byte lowest and cut to the output width.
  always_comb begin
    packed_atom = '0;
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      if (CW'(i) < atom_count_r) begin
        packed_atom[8*i +: 8] = atom_chars_r[i];
      end
    end
    count_ext = 4'(atom_count_r);
    atom_res.text   = packed_atom[TEXT_W-1:0];
    atom_res.len    = count_ext[LEN_W-1:0];
    atom_res.status = ST_TOKEN;
    atom_res.last   = 1'b1;
    delim_res.text   = TEXT_W'(in_byte);
    delim_res.len    = LEN_W'(1);
    delim_res.status = ST_TOKEN;
    delim_res.last   = 1'b1;
  end

  always_comb begin
    in_comment_nxt = in_comment_r;
    in_atom_nxt    = in_atom_r;
    atom_count_nxt = atom_count_r;
    atom_chars_nxt = atom_chars_r;
    n_push         = 2'd0;
    res0           = delim_res;
    res1           = delim_res;

    if (accept) begin
      priority if (in_end_of_input) begin
        in_comment_nxt = 1'b0;
        in_atom_nxt    = 1'b0;
        atom_count_nxt = '0;
        n_push         = 2'd1;
        res0.text      = '0;
        res0.len       = '0;
        res0.status    = ST_END;
      end else if (in_comment_r) begin
        if (in_byte == CH_NL) begin
          in_comment_nxt = 1'b0;
        end
      end else if (!in_atom_r) begin
        priority if (in_byte == CH_SEMI) begin
          in_comment_nxt = 1'b1;
        end else if (is_space(in_byte)) begin
        end else if (is_delim(in_byte)) begin
          n_push = 2'd1;
        end else begin
          atom_chars_nxt[0] = in_byte;
          atom_count_nxt    = CW'(1);
          in_atom_nxt       = 1'b1;
        end
      end else begin
        priority if (is_delim(in_byte)) begin
          // The atom goes out first, then the delimiter that closed it.
          n_push         = 2'd2;
          res0           = atom_res;
          res0.last      = 1'b0;
          in_atom_nxt    = 1'b0;
          atom_count_nxt = '0;
        end else if (is_space(in_byte)) begin
          n_push         = 2'd1;
          res0           = atom_res;
          in_atom_nxt    = 1'b0;
          atom_count_nxt = '0;
        end else if (atom_count_r < CW'(MAX_TOKEN_CHARS)) begin
          for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
            if (CW'(i) == atom_count_r) begin
              atom_chars_nxt[i] = in_byte;
            end
          end
          atom_count_nxt = atom_count_r + CW'(1);
        end else begin
          n_push         = 2'd1;
          res0.text      = '0;
          res0.len       = '0;
          res0.status    = ST_OVERFLOW;
          in_atom_nxt    = 1'b0;
          atom_count_nxt = '0;
        end
      end
    end
  end

  // Result queue: the head sits in slot 0, new results append behind the tail.
  always_comb begin
    logic [1:0] c;
    q_nxt = q_r;
    c     = q_count_r;
    if (pop) begin
      for (int i = 0; i < QD - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      c = c - 2'd1;
    end
    for (int i = 0; i < QD; i++) begin
      if ((n_push != 2'd0) && (2'(i) == c)) begin
        q_nxt[i] = res0;
      end
      if ((n_push == 2'd2) && (2'(i) == c + 2'd1)) begin
        q_nxt[i] = res1;
      end
    end
    q_count_nxt = c + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      in_atom_r    <= 1'b0;
      atom_count_r <= '0;
      q_count_r    <= 2'd0;
    end else begin
      in_comment_r <= in_comment_nxt;
      in_atom_r    <= in_atom_nxt;
      atom_count_r <= atom_count_nxt;
      q_count_r    <= q_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    atom_chars_r <= atom_chars_nxt;
    q_r          <= q_nxt;
  end

endmodule

// ===== verif/tb_sexpr_token_scanner.sv =====
`timescale 1ns / 100ps

module tb_sexpr_token_scanner;
  import sts_pkg::*;

  localparam int MAX_CHARS = 6;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_GAP = 17;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte;
  logic              in_end_of_input;
  logic              out_valid;
  logic              out_stall;
  logic [TEXT_W-1:0] out_token_text;
  logic [LEN_W-1:0]  out_token_length;
  logic [1:0]        out_status;
  logic              out_last_of_run;

  sexpr_token_scanner #(.MAX_TOKEN_CHARS(MAX_CHARS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_text   (out_token_text),
    .out_token_length (out_token_length),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

  // Scanner state as the tokenizer should hold it.
  logic       skipping_comment;
  logic       collecting;
  logic [7:0] atom_bytes [MAX_CHARS];
  int         atom_len;

  result_t expected_tokens [$];
  int      mismatches = 0;
  int      counted_items = 0;
  bit      sender_busy = 1'b0;
  bit      receiver_busy = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic bit delim_byte(input logic [7:0] b);
    case (b)
      CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_NUL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit blank_byte(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int draw_gap(input bit busy);
    if (busy || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [TEXT_W-1:0] atom_text();
    logic [TEXT_W-1:0] t;
    t = '0;
    for (int i = 0; i < atom_len && i < TEXT_W / 8; i++) t[8*i +: 8] = atom_bytes[i];
    return t;
  endfunction

  task automatic drop_atom();
    for (int i = 0; i < MAX_CHARS; i++) atom_bytes[i] = '0;
    atom_len = 0;
    collecting = 1'b0;
  endtask

  task automatic push_token(input logic [TEXT_W-1:0] text, input int len,
                            input status_t st, input logic last);
    result_t r;
    r.text = text;
    r.len = len[LEN_W-1:0];
    r.status = st;
    r.last = last;
    expected_tokens.push_back(r);
  endtask

  // Advances the tokenizer by one accepted byte and queues the tokens it yields.
  task automatic scan_byte(input logic [7:0] b, input logic eoi);
    if (eoi) begin
      skipping_comment = 1'b0;
      drop_atom();
      push_token('0, 0, ST_END, 1'b1);
    end else if (skipping_comment) begin
      if (b == CH_NL) skipping_comment = 1'b0;
    end else if (!collecting) begin
      if (b == CH_SEMI) begin
        skipping_comment = 1'b1;
      end else if (blank_byte(b)) begin
      end else if (delim_byte(b)) begin
        push_token(TEXT_W'(b), 1, ST_TOKEN, 1'b1);
      end else begin
        drop_atom();
        atom_bytes[0] = b;
        atom_len = 1;
        collecting = 1'b1;
      end
    end else if (delim_byte(b)) begin
      push_token(atom_text(), atom_len, ST_TOKEN, 1'b0);
      push_token(TEXT_W'(b), 1, ST_TOKEN, 1'b1);
      drop_atom();
    end else if (blank_byte(b)) begin
      push_token(atom_text(), atom_len, ST_TOKEN, 1'b1);
      drop_atom();
    end else if (atom_len < MAX_CHARS) begin
      atom_bytes[atom_len] = b;
      atom_len++;
    end else begin
      // The byte that would overflow the buffer is lost along with the atom.
      drop_atom();
      push_token('0, 0, ST_OVERFLOW, 1'b1);
    end
  endtask

  // Issues one request and returns at the clock edge that accepts it.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = draw_gap(sender_busy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    scan_byte(b, eoi);
    counted_items++;
  endtask

  function automatic logic [7:0] random_atom_byte(input bit first);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (delim_byte(b) || blank_byte(b) || (first && b == CH_SEMI));
    return b;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] random_delim();
    case ($urandom_range(0, 3))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_QUOTE;
      default: return CH_NUL;
    endcase
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_token();
    result_t want;
    if (expected_tokens.size() == 0) begin
      note_failure($sformatf("unexpected token text %h len %0d status %0d last %0d",
                             out_token_text, out_token_length, out_status,
                             out_last_of_run));
      return;
    end
    want = expected_tokens.pop_front();
    if (out_token_text !== want.text || out_token_length !== want.len ||
        out_status !== want.status || out_last_of_run !== want.last)
      note_failure($sformatf({"expected text %h len %0d status %0d last %0d, ",
                              "got text %h len %0d status %0d last %0d"},
                             want.text, want.len, want.status, want.last,
                             out_token_text, out_token_length, out_status,
                             out_last_of_run));
  endtask

  // Checks each result when its request is about to be taken, then may stall a while.
  initial begin
    int stall_cycles;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        check_token();
        stall_cycles = draw_gap(receiver_busy);
        @(posedge clk);
        if (stall_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (stall_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic test_single_char_tokens();
    send_item(CH_LPAREN, 1'b0);
    send_item(CH_RPAREN, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_NUL, 1'b0);
  endtask

  // A full-length atom holding a semicolon and high bytes, closed by a delimiter.
  task automatic test_full_atom_with_delimiter();
    send_item("a", 1'b0);
    send_item(CH_SEMI, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_item("z", 1'b0);
    send_item("9", 1'b0);
    send_item(CH_RPAREN, 1'b0);
  endtask

  task automatic test_atom_overflow();
    for (int i = 0; i <= MAX_CHARS; i++) send_item(8'(8'h31 + i), 1'b0);
  endtask

  task automatic test_comment_and_end();
    send_item(CH_SEMI, 1'b0);
    send_item(CH_LPAREN, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item("q", 1'b0);
    send_item(CH_CR, 1'b0);
    send_item("w", 1'b0);
    send_item(8'h5a, 1'b1);
    send_item(8'ha5, 1'b1);
  endtask

  // Mostly well-formed source text with random content, plus raw noise bytes.
  task automatic test_random_streams();
    int goal;
    int pick;
    int len;
    goal = counted_items + RANDOM_ITEMS;
    while (counted_items < goal) begin
      if ($urandom_range(0, 39) == 0) sender_busy = !sender_busy;
      if ($urandom_range(0, 39) == 0) receiver_busy = !receiver_busy;
      pick = $urandom_range(0, 19);
      if (pick <= 8) begin
        len = (pick == 8) ? $urandom_range(MAX_CHARS + 1, MAX_CHARS + 2)
                          : $urandom_range(1, MAX_CHARS);
        for (int i = 0; i < len; i++) send_item(random_atom_byte(i == 0), 1'b0);
        case ($urandom_range(0, 2))
          0: send_item(random_blank(), 1'b0);
          1: send_item(random_delim(), 1'b0);
          default: ;
        endcase
      end else if (pick <= 11) begin
        send_item(random_delim(), 1'b0);
      end else if (pick <= 13) begin
        repeat ($urandom_range(1, 3)) send_item(random_blank(), 1'b0);
      end else if (pick <= 15) begin
        send_item(CH_SEMI, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          logic [7:0] c;
          do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          send_item(c, 1'b0);
        end
        send_item(CH_NL, 1'b0);
      end else if (pick == 16) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= '0;
    in_end_of_input <= 1'b0;
    skipping_comment = 1'b0;
    drop_atom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_char_tokens();
    test_full_atom_with_delimiter();
    test_atom_overflow();
    test_comment_and_end();
    test_random_streams();

    in_valid <= 1'b0;
    receiver_busy = 1'b1;
    while (expected_tokens.size() != 0) @(posedge clk);
    // Leave room for any stray result to show up.
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("sexpr_token_scanner verification clean");
    end else begin
      $display("sexpr_token_scanner verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sexpr_token_scanner verification failed");
    $finish;
  end

endmodule
